// ===== rtl/mvhp_pkg.sv =====
// Shared types and constants for the MPEG video header parser.
// No dependencies; the parser top and the core import this package.
package mvhp_pkg;

    // Start-code values
    localparam logic [7:0] SC_PICTURE    = 8'h00;
    localparam logic [7:0] SC_SLICE_LAST = 8'hAF;
    localparam logic [7:0] SC_SEQUENCE   = 8'hB3;
    localparam logic [7:0] SC_EXTENSION  = 8'hB5;
    localparam logic [7:0] SC_GOP        = 8'hB8;

    // Extension identifiers
    localparam logic [3:0] EXT_SEQUENCE = 4'd1;
    localparam logic [3:0] EXT_DISPLAY  = 4'd2;
    localparam logic [3:0] EXT_PIC_CODE = 4'd8;

    // Picture coding types that carry f_codes
    localparam logic [2:0] CODING_P = 3'd2;
    localparam logic [2:0] CODING_B = 3'd3;

    // Last header byte index of each header kind
    localparam logic [2:0] SEQ_LAST      = 3'd7;
    localparam logic [2:0] GOP_LAST      = 3'd3;
    localparam logic [2:0] PIC_BASE_LAST = 3'd3;
    localparam logic [2:0] PIC_EXT_LAST  = 3'd4;
    localparam logic [2:0] EXT_SEQ_LAST  = 3'd5;
    localparam logic [2:0] EXT_PIC_LAST  = 3'd4;

    localparam int HDR_DEPTH = 5;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_MARKER = 3'd1,
        PH_SEQ    = 3'd2,
        PH_EXT    = 3'd3,
        PH_GOP    = 3'd4,
        PH_PIC    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_SLICE     = 2'd0,
        ST_END       = 2'd1,
        ST_TRUNC     = 2'd2,
        ST_UNHANDLED = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  slice_code;
        logic [13:0] frame_width;
        logic [13:0] frame_height;
        logic [9:0]  temporal_order;
        logic [2:0]  coding_kind;
        logic [15:0] motion_ranges;
        logic [1:0]  dc_precision;
        logic [1:0]  structure_kind;
        logic [7:0]  mode_flags;
        logic [15:0] group_count;
    } t_result;

endpackage

// ===== rtl/mvhp_if.sv =====
// Valid/ready channel interfaces for the stream input and the result output.
// Depends on nothing; payload fields are plain vectors.
interface mvhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       stream_end;

    modport source (output valid, output stream_byte, output stream_end, input ready);
    modport sink   (input valid, input stream_byte, input stream_end, output ready);
endinterface

interface mvhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  slice_code;
    logic [13:0] frame_width;
    logic [13:0] frame_height;
    logic [9:0]  temporal_order;
    logic [2:0]  coding_kind;
    logic [15:0] motion_ranges;
    logic [1:0]  dc_precision;
    logic [1:0]  structure_kind;
    logic [7:0]  mode_flags;
    logic [15:0] group_count;

    modport source (output valid, output status, output slice_code, output frame_width,
                    output frame_height, output temporal_order, output coding_kind,
                    output motion_ranges, output dc_precision, output structure_kind,
                    output mode_flags, output group_count, input ready);
    modport sink   (input valid, input status, input slice_code, input frame_width,
                    input frame_height, input temporal_order, input coding_kind,
                    input motion_ranges, input dc_precision, input structure_kind,
                    input mode_flags, input group_count, output ready);
endinterface

// ===== rtl/mpeg_video_header_parser.sv =====
// MPEG-1/2 video header parser: start-code search, header decode, slice reporting.
// A result passes through the input register, then the result register, to o_out.
// Throughput: one stream byte per cycle, set by the single parse step; stall only while the
// result register is full and not being taken.
// Reset (i_rst_n low, synchronous): parse state, held parameters and GOP count clear.
// Depends on mvhp_pkg, mvhp_in_if, mvhp_out_if and mvhp_core.
module mpeg_video_header_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mvhp_in_if.sink    i_in,
    mvhp_out_if.source o_out
);
    import mvhp_pkg::*;

    // Input register: holds one byte request until the parse step takes it
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // Result register
    logic       r_out_valid;
    t_result    r_out;

    logic       w_fire;
    logic       w_res_valid;
    t_result    w_res;

    // Advance the parse step whenever a byte is held and the result slot is free
    // or is being drained this cycle.
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Payload needs no reset; load on every accepted request
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.stream_byte;
            r_in_end  <= i_in.stream_end;
        end
    end

    mvhp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (r_in_byte),
        .i_end       (r_in_end),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Drop the result once taken; load a new one when the parse step makes one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_res_valid || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.slice_code     = r_out.slice_code;
    assign o_out.frame_width    = r_out.frame_width;
    assign o_out.frame_height   = r_out.frame_height;
    assign o_out.temporal_order = r_out.temporal_order;
    assign o_out.coding_kind    = r_out.coding_kind;
    assign o_out.motion_ranges  = r_out.motion_ranges;
    assign o_out.dc_precision   = r_out.dc_precision;
    assign o_out.structure_kind = r_out.structure_kind;
    assign o_out.mode_flags     = r_out.mode_flags;
    assign o_out.group_count    = r_out.group_count;

endmodule

// ===== rtl/mvhp_core.sv =====
// Parse state machine and held picture parameters; one stream byte per i_fire.
// Depends on mvhp_pkg.
module mvhp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    output logic              o_res_valid,
    output mvhp_pkg::t_result o_res
);
    import mvhp_pkg::*;

    t_phase      r_phase, n_phase, w_step_phase;
    logic [2:0]  r_idx, n_idx;
    logic [1:0]  r_zero, n_zero;
    logic [7:0]  r_hdr [HDR_DEPTH];
    logic [7:0]  w_hv  [HDR_DEPTH];

    logic [13:0] r_width, n_width;
    logic [13:0] r_height, n_height;
    logic [9:0]  r_temporal, n_temporal;
    logic [2:0]  r_coding, n_coding;
    logic [15:0] r_motion, n_motion;
    logic [1:0]  r_dc, n_dc;
    logic [1:0]  r_structure, n_structure;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_gop, n_gop;

    logic        w_in_hdr;
    logic [3:0]  w_ext_id;
    logic [2:0]  w_ext_last;
    logic [2:0]  w_pic_coding;
    logic [2:0]  w_fc;
    logic [2:0]  w_bc;
    logic        w_st_valid;
    t_status     w_status;
    logic [7:0]  w_slice;

    assign w_in_hdr = (r_phase inside {PH_SEQ, PH_EXT, PH_GOP, PH_PIC});

    // Header view: the byte being written this cycle is visible at its own index
    always_comb begin
        for (int i = 0; i < HDR_DEPTH; i++) begin
            w_hv[i] = (w_in_hdr && r_idx == 3'(i)) ? i_byte : r_hdr[i];
        end
    end

    assign w_ext_id     = w_hv[0][7:4];
    assign w_ext_last   = (w_ext_id == EXT_SEQUENCE) ? EXT_SEQ_LAST : EXT_PIC_LAST;
    assign w_pic_coding = w_hv[1][5:3];
    assign w_fc         = {w_hv[3][1:0], w_hv[4][7]};
    assign w_bc         = w_hv[4][5:3];

    // Next parse state
    always_comb begin
        w_step_phase = r_phase;
        n_idx        = r_idx;
        n_zero       = r_zero;
        case (r_phase)
            PH_SEARCH: begin
                if (i_byte == 8'h00) begin
                    if (r_zero != 2'd2) n_zero = r_zero + 2'd1;
                end else if (i_byte == 8'h01 && r_zero == 2'd2) begin
                    w_step_phase = PH_MARKER;
                    n_zero       = 2'd0;
                end else begin
                    n_zero = 2'd0;
                end
            end
            PH_MARKER: begin
                n_idx = 3'd0;
                case (i_byte)
                    SC_PICTURE:   w_step_phase = PH_PIC;
                    SC_SEQUENCE:  w_step_phase = PH_SEQ;
                    SC_EXTENSION: w_step_phase = PH_EXT;
                    SC_GOP:       w_step_phase = PH_GOP;
                    default:      w_step_phase = PH_SEARCH;
                endcase
            end
            PH_SEQ: begin
                if (r_idx == SEQ_LAST) w_step_phase = PH_SEARCH;
                else                   n_idx = r_idx + 3'd1;
            end
            PH_GOP: begin
                if (r_idx == GOP_LAST) w_step_phase = PH_SEARCH;
                else                   n_idx = r_idx + 3'd1;
            end
            PH_EXT: begin
                if (r_idx == 3'd0) begin
                    if (w_ext_id inside {EXT_SEQUENCE, EXT_PIC_CODE}) n_idx = 3'd1;
                    else                                             w_step_phase = PH_SEARCH;
                end else if (r_idx == w_ext_last) begin
                    w_step_phase = PH_SEARCH;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_PIC: begin
                if (r_idx == PIC_BASE_LAST) begin
                    if (w_pic_coding inside {CODING_P, CODING_B}) n_idx = r_idx + 3'd1;
                    else                                          w_step_phase = PH_SEARCH;
                end else if (r_idx == PIC_EXT_LAST) begin
                    w_step_phase = PH_SEARCH;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            default: w_step_phase = PH_SEARCH;
        endcase
        n_phase = w_step_phase;
        if (i_end) begin
            n_phase = PH_SEARCH;
            n_idx   = 3'd0;
            n_zero  = 2'd0;
        end
    end

    // Field latching and result
    always_comb begin
        n_width     = r_width;
        n_height    = r_height;
        n_temporal  = r_temporal;
        n_coding    = r_coding;
        n_motion    = r_motion;
        n_dc        = r_dc;
        n_structure = r_structure;
        n_flags     = r_flags;
        n_gop       = r_gop;
        w_st_valid  = 1'b0;
        w_status    = ST_SLICE;
        w_slice     = 8'h00;
        case (r_phase)
            PH_MARKER: begin
                if (i_byte inside {[8'h01:SC_SLICE_LAST]}) begin
                    w_st_valid = 1'b1;
                    w_status   = ST_SLICE;
                    w_slice    = i_byte;
                end
            end
            PH_SEQ: begin
                if (r_idx == SEQ_LAST) begin
                    n_width  = {2'b00, w_hv[0], w_hv[1][7:4]};
                    n_height = {2'b00, w_hv[1][3:0], w_hv[2]};
                end
            end
            PH_GOP: begin
                if (r_idx == GOP_LAST) n_gop = r_gop + 16'd1;
            end
            PH_EXT: begin
                if (r_idx == 3'd0) begin
                    if (!(w_ext_id inside {EXT_SEQUENCE, EXT_DISPLAY, EXT_PIC_CODE})) begin
                        w_st_valid = 1'b1;
                        w_status   = ST_UNHANDLED;
                    end
                end else if (r_idx == w_ext_last) begin
                    if (w_ext_id == EXT_SEQUENCE) begin
                        n_width  = r_width | {w_hv[1][0], w_hv[2][7], 12'h000};
                        n_height = r_height | {w_hv[2][6:5], 12'h000};
                    end else begin
                        n_motion    = {w_hv[0][3:0], w_hv[1], w_hv[2][7:4]};
                        n_dc        = w_hv[2][3:2];
                        n_structure = w_hv[2][1:0];
                        n_flags     = {w_hv[3][7:2], r_flags[1:0]};
                    end
                end
            end
            PH_PIC: begin
                if (r_idx == PIC_BASE_LAST) begin
                    n_temporal = {w_hv[0], w_hv[1][7:6]};
                    n_coding   = w_pic_coding;
                    if (!(w_pic_coding inside {CODING_P, CODING_B})) begin
                        n_flags     = {2'b11, r_flags[5:2], 2'b00};
                        n_motion    = 16'h0000;
                        n_structure = 2'd3;
                    end
                end else if (r_idx == PIC_EXT_LAST) begin
                    n_flags     = {2'b11, r_flags[5:2], w_hv[3][2], r_flags[0]};
                    n_motion    = {1'b0, w_fc, 1'b0, w_fc, r_motion[7:0]};
                    n_structure = 2'd3;
                    if (r_coding == CODING_B) begin
                        n_flags[0]     = w_hv[4][6];
                        n_motion[7:0]  = {1'b0, w_bc, 1'b0, w_bc};
                    end
                end
            end
            default: ;
        endcase
        if (i_end && !w_st_valid) begin
            w_st_valid = 1'b1;
            w_status   = (w_step_phase inside {PH_SEQ, PH_EXT, PH_GOP, PH_PIC})
                         ? ST_TRUNC : ST_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_idx       <= 3'd0;
            r_zero      <= 2'd0;
            r_width     <= '0;
            r_height    <= '0;
            r_temporal  <= '0;
            r_coding    <= '0;
            r_motion    <= '0;
            r_dc        <= '0;
            r_structure <= '0;
            r_flags     <= '0;
            r_gop       <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_zero      <= n_zero;
            r_width     <= n_width;
            r_height    <= n_height;
            r_temporal  <= n_temporal;
            r_coding    <= n_coding;
            r_motion    <= n_motion;
            r_dc        <= n_dc;
            r_structure <= n_structure;
            r_flags     <= n_flags;
            r_gop       <= n_gop;
        end
    end

    // Header byte store, no reset: only bytes of the current header are read
    always_ff @(posedge i_clk) begin
        if (i_fire && w_in_hdr && r_idx < 3'(HDR_DEPTH)) begin
            r_hdr[r_idx] <= i_byte;
        end
    end

    assign o_res_valid          = i_fire && w_st_valid;
    assign o_res.status         = w_status;
    assign o_res.slice_code     = w_slice;
    assign o_res.frame_width    = n_width;
    assign o_res.frame_height   = n_height;
    assign o_res.temporal_order = n_temporal;
    assign o_res.coding_kind    = n_coding;
    assign o_res.motion_ranges  = n_motion;
    assign o_res.dc_precision   = n_dc;
    assign o_res.structure_kind = n_structure;
    assign o_res.mode_flags     = n_flags;
    assign o_res.group_count    = n_gop;

endmodule
